/* sv/iir_position_estimator_macros.svh */
// assertion macros for the position estimator checker
`ifndef IIR_POSITION_ESTIMATOR_MACROS_SVH
`define IIR_POSITION_ESTIMATOR_MACROS_SVH

// same-cycle implication, ignored while reset is held
`define IIRPE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while reset is held
`define IIRPE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that is checked during reset as well
`define IIRPE_ASSERT_RST_NXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/iirpe_pkg.sv */
// shared types and constants of the iir position estimator
`default_nettype none

package iirpe_pkg;

    // coefficient format, output scaling and filter sizes
    localparam int COEF_W     = 24;
    localparam int FRAC_SHIFT = 19;
    localparam int EST_W      = 24;
    localparam int NUM_COEF   = 7;
    localparam int HIST_DEPTH = 5;
    localparam int IDX_W      = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_B_NOW   = 3'd0;
    localparam logic [IDX_W-1:0] REG_B_PREV  = 3'd1;
    localparam logic [IDX_W-1:0] REG_A_LAG1  = 3'd2;
    localparam logic [IDX_W-1:0] REG_A_LAG2  = 3'd3;
    localparam logic [IDX_W-1:0] REG_A_LAG3  = 3'd4;
    localparam logic [IDX_W-1:0] REG_A_LAG4  = 3'd5;
    localparam logic [IDX_W-1:0] REG_A_LAG5  = 3'd6;

    // reset coefficients in register order, q4.19
    localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_COEF] = '{
        24'sd0,
        24'sd10124,
        -24'sd1905787,
        24'sd2979529,
        -24'sd2475164,
        24'sd1084228,
        -24'sd198810
    };

    // one result item
    typedef struct packed {
        logic signed [EST_W-1:0] estimate;
        logic                    saturated;
    } out_item_t;

endpackage

`default_nettype wire

/* sv/iirpe_cell.sv */
// one delay cell: holds a delayed value and weights it by its coefficient
`default_nettype none

module iirpe_cell #(
    parameter int DATA_W = 24
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   shift_en,
    input  wire logic signed [DATA_W-1:0]               din,
    input  wire logic signed [iirpe_pkg::COEF_W-1:0]    coef,
    output logic signed [DATA_W-1:0]                    dout,
    output logic signed [iirpe_pkg::COEF_W+DATA_W-1:0]  prod
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    // take the neighbor's value on every accepted transaction
    always_comb begin
        value_next = value_reg;
        if (shift_en) begin
            value_next = din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else begin
            value_reg <= value_next;
        end
    end

    // exact product of the held value and the coefficient
    assign prod = coef * value_reg;
    assign dout = value_reg;

endmodule

`default_nettype wire

/* sv/iirpe_out_buf.sv */
// two-entry result buffer that decouples the filter from the receiver
`default_nettype none

module iirpe_out_buf (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire iirpe_pkg::out_item_t  push_item,
    input  wire logic                  pop,
    output logic                       full,
    output logic                       valid,
    output iirpe_pkg::out_item_t       head
);

    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    iirpe_pkg::out_item_t head_reg;
    iirpe_pkg::out_item_t head_next;
    iirpe_pkg::out_item_t spare_reg;
    iirpe_pkg::out_item_t spare_next;

    // slot movement for push, pop or both
    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        spare_next = spare_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
            if (count_reg == 2'd0) begin
                head_next = push_item;
            end else begin
                spare_next = push_item;
            end
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
            head_next  = spare_reg;
        end else if (pop && push) begin
            if (count_reg == 2'd1) begin
                head_next = push_item;
            end else begin
                head_next  = spare_reg;
                spare_next = push_item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = head_reg;

endmodule

`default_nettype wire

/* sv/iir_position_estimator.sv */
// top level of the fifth-order direct-form-i position estimator
//
// Samples arrive on the s_ stream channel, one per transaction, and every
// sample gives exactly one estimate on the m_ stream channel, with the clip
// flag in m_tuser. The filter arithmetic (seven products, one exact sum,
// rounding and saturation) happens in the cycle the sample is accepted, so
// a new sample can be taken on every clock while a result buffer
// entry is free: throughput is one sample per cycle; results are registered.
// The rate is set by the feedback path from the newest output through the
// first delay cell's multiplier and the adder tree back into that cell.
// A two-entry result buffer sits before the m_ ports; s_tready is high while
// it has a free entry, so one result can wait on a stalled receiver while
// the next sample is still taken. With both entries waiting, s_tready drops
// until the receiver takes one.
// Synchronous reset (aresetn low) empties the buffer, clears the previous
// sample and the output history to zero and loads the default coefficients.
// Coefficients are written through cfg_wr_en/cfg_index/cfg_data while no
// sample is in flight; an index beyond the list is ignored.
`default_nettype none

module iir_position_estimator #(
    parameter int SAMPLE_WIDTH  = 18,
    parameter int HISTORY_WIDTH = 24
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [iirpe_pkg::IDX_W-1:0]         cfg_index,
    input  wire logic [iirpe_pkg::COEF_W-1:0]        cfg_data,
    // sample input
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // fields from bit 0: sample
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,
    // estimate output
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // fields from bit 0: estimate
    output logic [iirpe_pkg::EST_W-1:0]              m_tdata,
    // fields from bit 0: saturated
    output logic [0:0]                               m_tuser
);

    localparam int CW     = iirpe_pkg::COEF_W;
    localparam int DW     = (SAMPLE_WIDTH > HISTORY_WIDTH) ? SAMPLE_WIDTH : HISTORY_WIDTH;
    localparam int ACC_W  = CW + DW + 4;
    localparam int RND_W  = ACC_W - iirpe_pkg::FRAC_SHIFT;
    localparam int NCOEF  = iirpe_pkg::NUM_COEF;
    localparam int NHIST  = iirpe_pkg::HIST_DEPTH;

    logic signed [CW-1:0]              coef_reg [NCOEF];
    logic signed [SAMPLE_WIDTH-1:0]    sample;
    logic                              accept;
    logic signed [CW+SAMPLE_WIDTH-1:0] prod_now;
    logic signed [CW+SAMPLE_WIDTH-1:0] prod_prev;
    logic signed [SAMPLE_WIDTH-1:0]    prev_dout;
    logic signed [HISTORY_WIDTH-1:0]   hist_dout [NHIST];
    logic signed [CW+HISTORY_WIDTH-1:0] hist_prod [NHIST];
    logic signed [ACC_W-1:0]           acc;
    logic signed [ACC_W-1:0]           acc_rnd;
    logic signed [RND_W-1:0]           rounded;
    logic [RND_W-HISTORY_WIDTH:0]      upper;
    logic                              pos_ovf;
    logic                              neg_ovf;
    logic signed [HISTORY_WIDTH-1:0]   clipped;
    iirpe_pkg::out_item_t              new_item;
    iirpe_pkg::out_item_t              head;
    logic                              buf_full;
    logic                              buf_valid;
    logic                              pop;

    // coefficient registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NCOEF; i++) begin
                coef_reg[i] <= iirpe_pkg::COEF_RESET[i];
            end
        end else if (cfg_wr_en) begin
            for (int i = 0; i < NCOEF; i++) begin
                if (cfg_index == iirpe_pkg::IDX_W'(i)) begin
                    coef_reg[i] <= cfg_data;
                end
            end
        end
    end

    assign sample   = s_tdata[SAMPLE_WIDTH-1:0];
    assign accept   = s_tvalid && s_tready;
    assign prod_now = coef_reg[iirpe_pkg::REG_B_NOW] * sample;

    // previous-sample cell
    iirpe_cell #(
        .DATA_W (SAMPLE_WIDTH)
    ) u_prev_cell (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (accept),
        .din      (sample),
        .coef     (coef_reg[iirpe_pkg::REG_B_PREV]),
        .dout     (prev_dout),
        .prod     (prod_prev)
    );

    // output history as a row of cells, newest first
    for (genvar g = 0; g < NHIST; g++) begin : g_hist
        logic signed [HISTORY_WIDTH-1:0] cell_din;
        if (g == 0) begin : g_head
            assign cell_din = clipped;
        end else begin : g_body
            assign cell_din = hist_dout[g-1];
        end
        iirpe_cell #(
            .DATA_W (HISTORY_WIDTH)
        ) u_hist_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (accept),
            .din      (cell_din),
            .coef     (coef_reg[int'(iirpe_pkg::REG_A_LAG1) + g]),
            .dout     (hist_dout[g]),
            .prod     (hist_prod[g])
        );
    end

    // exact sum of all terms, feedback terms subtracted
    always_comb begin
        acc = ACC_W'(prod_now) + ACC_W'(prod_prev);
        for (int i = 0; i < NHIST; i++) begin
            acc = acc - ACC_W'(hist_prod[i]);
        end
    end

    // round half up to an integer (q.0)
    assign acc_rnd = acc + (ACC_W'(1) <<< (iirpe_pkg::FRAC_SHIFT - 1));
    assign rounded = acc_rnd[ACC_W-1:iirpe_pkg::FRAC_SHIFT];

    // saturate to the history width
    assign upper   = rounded[RND_W-1:HISTORY_WIDTH-1];
    assign pos_ovf = !rounded[RND_W-1] && (|upper);
    assign neg_ovf = rounded[RND_W-1] && !(&upper);

    always_comb begin
        if (pos_ovf) begin
            clipped = {1'b0, {(HISTORY_WIDTH-1){1'b1}}};
        end else if (neg_ovf) begin
            clipped = {1'b1, {(HISTORY_WIDTH-1){1'b0}}};
        end else begin
            clipped = rounded[HISTORY_WIDTH-1:0];
        end
    end

    assign new_item.estimate  = iirpe_pkg::EST_W'(clipped);
    assign new_item.saturated = pos_ovf || neg_ovf;

    // result buffer
    assign pop = m_tvalid && m_tready;

    iirpe_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_item (new_item),
        .pop       (pop),
        .full      (buf_full),
        .valid     (buf_valid),
        .head      (head)
    );

    assign s_tready   = !buf_full;
    assign m_tvalid   = buf_valid;
    assign m_tdata    = head.estimate;
    assign m_tuser[0] = head.saturated;

endmodule

`default_nettype wire

/* sv/iirpe_checker.sv */
// port-level checker for the position estimator, bound to the top level
`default_nettype none

`include "iir_position_estimator_macros.svh"

module iirpe_checker #(
    parameter int HISTORY_WIDTH = 24
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [iirpe_pkg::EST_W-1:0]   m_tdata,
    input wire logic [0:0]                    m_tuser
);

    // clip limits as they show in the estimate field
    localparam logic signed [63:0] MAXV = (64'sd1 <<< (HISTORY_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] MINV = -MAXV - 64'sd1;
    localparam logic [iirpe_pkg::EST_W-1:0] SAT_HI = MAXV[iirpe_pkg::EST_W-1:0];
    localparam logic [iirpe_pkg::EST_W-1:0] SAT_LO = MINV[iirpe_pkg::EST_W-1:0];

    // reset empties the result buffer
    `IIRPE_ASSERT_RST_NXT(a_reset_empty, aclk, !aresetn, !m_tvalid, "result valid after reset")

    // a stalled result holds
    `IIRPE_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // a clipped result sits at one of the limits
    `IIRPE_ASSERT_IMP(a_sat_limit, aclk, aresetn, m_tvalid && m_tuser[0], (m_tdata == SAT_HI) || (m_tdata == SAT_LO), "clip flag without limit value")

    // input backpressure only while results wait
    `IIRPE_ASSERT_IMP(a_ready_low, aclk, aresetn, !s_tready, m_tvalid, "input stalled with no result pending")

    // taking a result from a full buffer frees an entry
    `IIRPE_ASSERT_NXT(a_ready_back, aclk, aresetn, !s_tready && m_tvalid && m_tready, s_tready, "ready not restored after transaction")

endmodule

bind iir_position_estimator iirpe_checker #(
    .HISTORY_WIDTH (HISTORY_WIDTH)
) u_iirpe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
